// File: rtl/linear_probe_key_table_assert.svh
// ----------------------------------------------------------------------------
// linear_probe_key_table_assert.svh
// Assertion macros used by the key table checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KEY_TABLE_ASSERT_SVH
`define LINEAR_PROBE_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, quiet during reset
`define LPKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, quiet during reset
`define LPKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lpkt_pkg.sv
// ----------------------------------------------------------------------------
// lpkt_pkg
// Types and constants of the linear probing key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

    // Default number of slots (power of two)
    localparam int unsigned SLOT_COUNT_DEF = 256;

    // Field widths of the channels
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned SLOT_W  = 8;
    localparam int unsigned COUNT_W = 9;

    // Result status codes
    typedef enum logic [1:0] {
        OUT_FOUND    = 2'd0,
        OUT_INSERTED = 2'd1,
        OUT_FULL     = 2'd2,
        OUT_INVALID  = 2'd3
    } outcome_t;

    // Control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ZERO,
        ST_PROBE
    } lpkt_state_t;

endpackage

// File: rtl/lpkt_key_ram.sv
// ----------------------------------------------------------------------------
// lpkt_key_ram
// Slot key store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpkt_key_ram
    import lpkt_pkg::*;
#(
    parameter int unsigned DEPTH = SLOT_COUNT_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/linear_probe_key_table.sv
// ----------------------------------------------------------------------------
// linear_probe_key_table
// Get-or-insert table of 64-bit keys with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one key per item. The result
//   channel m_valid/m_ready returns one item per key: slot index, outcome
//   (found, inserted, full, invalid zero key) and the entry count after it.
//   After reset a clearing pass writes every slot empty, one slot a cycle,
//   and s_ready stays low until the pass is done.
//   Probing: each probe is one registered read of the key memory and one
//   compare. A key is found, inserted or reported full after at most
//   SLOT_COUNT probes; a zero key needs no probe.
//   The next item is taken in the cycle after the result is registered.
//   A stalled receiver holds the result register; the block then waits with
//   the finished probe until the register frees, and accepts at most one
//   further item meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_key_table
    import lpkt_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KEY_W-1:0]   s_lookup_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOT_W-1:0]  m_slot_index,
    output logic [1:0]         m_outcome,
    output logic [COUNT_W-1:0] m_entries_used
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

    lpkt_state_t        state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   probe_reg, probe_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               m_valid_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    outcome_t           m_outcome_reg;
    logic [COUNT_W-1:0] m_count_reg;

    // Memory port signals
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic [KEY_W-1:0]   wr_data, rd_data;

    // Result to load
    logic               load_out;
    logic [IDX_W-1:0]   res_slot;
    outcome_t           res_outcome;
    logic [CNT_W-1:0]   res_count;

    logic               out_free, hit, empty, last;
    logic [IDX_W-1:0]   home, probe_inc;
    logic [IDX_W+SLOT_W-1:0]  slot_ext;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    lpkt_key_ram #(
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Probe compare on the slot just read
    assign home      = s_lookup_key[IDX_W-1:0];
    assign probe_inc = probe_reg + IDX_W'(1);
    assign hit       = (rd_data == key_reg);
    assign empty     = (rd_data == '0);
    assign last      = (step_reg == {IDX_W{1'b1}});
    assign out_free  = !m_valid_reg || m_ready;

    // Next state and datapath control
    always_comb begin
        state_next  = state_reg;
        key_next    = key_reg;
        probe_next  = probe_reg;
        step_next   = step_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = probe_inc;
        wr_en       = 1'b0;
        wr_addr     = probe_reg;
        wr_data     = key_reg;
        load_out    = 1'b0;
        res_slot    = '0;
        res_outcome = OUT_FULL;
        res_count   = count_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == {IDX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    key_next = s_lookup_key;
                    if (s_lookup_key == '0) begin
                        state_next = ST_ZERO;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = home;
                        probe_next = home;
                        step_next  = '0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_ZERO: begin
                res_outcome = OUT_INVALID;
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PROBE: begin
                if (hit || empty || last) begin
                    if (hit) begin
                        res_slot    = probe_reg;
                        res_outcome = OUT_FOUND;
                    end else if (empty) begin
                        res_slot    = probe_reg;
                        res_outcome = OUT_INSERTED;
                        res_count   = count_reg + CNT_W'(1);
                    end
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                        if (!hit && empty) begin
                            wr_en      = 1'b1;
                            count_next = res_count;
                        end
                    end
                end else begin
                    // slot taken by another key: read the next one
                    rd_en      = 1'b1;
                    probe_next = probe_inc;
                    step_next  = step_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Probe registers
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        probe_reg <= probe_next;
        step_reg  <= step_next;
    end

    // Fit results to the channel field widths
    assign slot_ext  = {{SLOT_W{1'b0}}, res_slot};
    assign count_ext = {{COUNT_W{1'b0}}, res_count};

    // Result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_slot_reg    <= slot_ext[SLOT_W-1:0];
            m_outcome_reg <= res_outcome;
            m_count_reg   <= count_ext[COUNT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_outcome      = m_outcome_reg;
    assign m_entries_used = m_count_reg;

endmodule

// File: rtl/lpkt_checker.sv
// ----------------------------------------------------------------------------
// lpkt_checker
// Port-level checks of the key table, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_key_table_assert.svh"

module lpkt_checker
    import lpkt_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [SLOT_W-1:0]  m_slot_index,
    input logic [1:0]         m_outcome,
    input logic [COUNT_W-1:0] m_entries_used
);

    // Entry count when every slot is taken, as the field shows it
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SLOT_COUNT);
    localparam bit COUNT_WRAPS = (SLOT_COUNT >= (1 << COUNT_W));

    // A stalled result item holds
    `LPKT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_slot_index) && $stable(m_outcome)
        && $stable(m_entries_used), "result item changed while stalled")

    // Full is only reported with every slot taken, and points at slot zero
    `LPKT_ASSERT_NOW(a_full_count, m_valid && m_outcome == OUT_FULL,
        m_entries_used == FULL_COUNT && m_slot_index == '0,
        "full outcome with free slots")

    // A rejected zero key reports slot zero
    `LPKT_ASSERT_NOW(a_invalid_slot, m_valid && m_outcome == OUT_INVALID,
        m_slot_index == '0, "invalid outcome with nonzero slot")

    // A found or inserted key implies at least one entry
    `LPKT_ASSERT_NOW(a_used_nonzero,
        m_valid && (m_outcome == OUT_FOUND || m_outcome == OUT_INSERTED),
        COUNT_WRAPS || m_entries_used != '0, "key held but entry count zero")

endmodule

bind linear_probe_key_table lpkt_checker #(.SLOT_COUNT(SLOT_COUNT)) u_lpkt_checker (.*);

// File: dv/linear_probe_key_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_key_table_test
// Checks the get-or-insert key table against a predictor of its own. A queue
// of key requests, filled at time zero, feeds a bursty driver. A monitor with
// its own stall pattern compares every result item with the oldest
// prediction. The table is walked through collisions, wraparound, zero keys
// and the full state.
// ----------------------------------------------------------------------------
module linear_probe_key_table_test;
    import lpkt_pkg::*;

    localparam int unsigned NUM_SLOTS      = SLOT_COUNT_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned END_HOLD       = 20;

    // Directed keys: extremes, bit patterns, collisions on slot 255 that wrap
    // round to slot 0, repeats that must be found and zero keys
    localparam logic [KEY_W-1:0] DIRECTED_KEYS [14] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_01FF,
        64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0001,
        64'h0000_0000_0000_0100,
        64'h0000_0000_0000_01FF,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0001,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555,
        64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FF00
    };

    // Home slots that random keys crowd onto, to build long probe chains
    localparam logic [7:0] HOT_HOMES [4] = '{8'hFE, 8'hFF, 8'h00, 8'h7F};

    typedef struct {
        logic [KEY_W-1:0] key;
        bit               wait_idle;
    } key_request_t;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot_index;
        outcome_t           outcome;
        logic [COUNT_W-1:0] entries_used;
    } lookup_result_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [KEY_W-1:0]   s_lookup_key   = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [SLOT_W-1:0]  m_slot_index;
    logic [1:0]         m_outcome;
    logic [COUNT_W-1:0] m_entries_used;

    // Shadow copy of the table
    logic [KEY_W-1:0]   shadow_keys [NUM_SLOTS];
    logic [COUNT_W-1:0] shadow_fill;

    key_request_t   pending_keys [$];
    lookup_result_t results_due [$];
    logic [KEY_W-1:0] known_keys [$];

    int unsigned keys_sent    = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned idle_cycles  = 0;

    linear_probe_key_table DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_lookup_key   (s_lookup_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_index   (m_slot_index),
        .m_outcome      (m_outcome),
        .m_entries_used (m_entries_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Get-or-insert on the shadow table; returns the result the key must give
    function automatic lookup_result_t get_or_insert(input logic [KEY_W-1:0] key);
        lookup_result_t res;
        int unsigned    home;
        int unsigned    pos;
        int unsigned    step;
        bit             done;
        res.key          = key;
        res.slot_index   = '0;
        res.outcome      = OUT_FULL;
        res.entries_used = shadow_fill;
        done             = 1'b0;
        if (key == '0) begin
            res.outcome = OUT_INVALID;
            return res;
        end
        home = int'(key & KEY_W'(NUM_SLOTS - 1));
        for (step = 0; step < NUM_SLOTS && !done; step++) begin
            pos = (home + step) & (NUM_SLOTS - 1);
            if (shadow_keys[pos] == key) begin
                res.slot_index = SLOT_W'(pos);
                res.outcome    = OUT_FOUND;
                done           = 1'b1;
            end else if (shadow_keys[pos] == '0) begin
                shadow_keys[pos] = key;
                if (shadow_fill < NUM_SLOTS)
                    shadow_fill = shadow_fill + 1'b1;
                res.slot_index   = SLOT_W'(pos);
                res.outcome      = OUT_INSERTED;
                res.entries_used = shadow_fill;
                done             = 1'b1;
            end
        end
        return res;
    endfunction

    // One random phase: fresh keys, repeats of earlier keys and zero keys.
    // The first item waits until the table has gone idle.
    task automatic queue_random_phase(input int unsigned count, input int unsigned fresh_pct);
        logic [KEY_W-1:0] key;
        logic [31:0]      rnd;
        int unsigned      roll;
        for (int unsigned i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                key = '0;
            end else if (roll < 4 + fresh_pct || known_keys.size() == 0) begin
                case ($urandom_range(0, 2))
                    0: key = {$urandom, $urandom};
                    1: begin
                        rnd = $urandom;
                        key = {$urandom, rnd[31:8], HOT_HOMES[$urandom_range(0, 3)]};
                    end
                    default: key = {56'($urandom_range(0, 3)), 8'($urandom)};
                endcase
                known_keys.push_back(key);
            end else begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            pending_keys.push_back('{key: key, wait_idle: (i == 0)});
        end
    endtask

    // Stimulus and end of run
    initial begin
        for (int i = 0; i < NUM_SLOTS; i++)
            shadow_keys[i] = '0;
        shadow_fill = '0;

        foreach (DIRECTED_KEYS[i]) begin
            pending_keys.push_back('{key: DIRECTED_KEYS[i], wait_idle: 1'b0});
            if (DIRECTED_KEYS[i] != '0)
                known_keys.push_back(DIRECTED_KEYS[i]);
        end
        // Fill phase, then mostly repeats once the table runs full
        queue_random_phase(600, 50);
        queue_random_phase(450, 36);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Look after the edge has settled so the driver's updates are seen
        while (pending_keys.size() != 0 || s_valid || results_due.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (END_HOLD) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Driver: bursts of items with random gaps; predicts on acceptance
    always @(posedge aclk) begin : drive_keys
        key_request_t req;
        int unsigned  burst_left;
        int unsigned  gap_left;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_lookup_key <= '0;
            burst_left = $urandom_range(1, 30);
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(get_or_insert(s_lookup_key));
                keys_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_keys.size() != 0 &&
                             (!pending_keys[0].wait_idle || keys_sent == results_seen)) begin
                    req = pending_keys.pop_front();
                    s_valid      <= 1'b1;
                    s_lookup_key <= req.key;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 7))
                            0, 1:    gap_left = 0;
                            2:       gap_left = $urandom_range(15, 40);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall pattern on m_ready and in-order result check
    always @(posedge aclk) begin : check_results
        lookup_result_t want;
        int unsigned    run_left;
        int unsigned    stall_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
            run_left   = 0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result item with none expected: slot %0d outcome %0d entries %0d",
                             $time, m_slot_index, m_outcome, m_entries_used);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    if (m_slot_index !== want.slot_index || m_outcome !== want.outcome ||
                        m_entries_used !== want.entries_used) begin
                        $display("%0t: key %h expected slot %0d outcome %0d entries %0d, %s",
                                 $time, want.key, want.slot_index, want.outcome,
                                 want.entries_used, "got");
                        $display("%0t: key %h actual   slot %0d outcome %0d entries %0d",
                                 $time, want.key, m_slot_index, m_outcome, m_entries_used);
                        error_count++;
                    end
                end
                results_seen <= results_seen + 1;
            end

            if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                run_left = $urandom_range(0, 25);
                case ($urandom_range(0, 5))
                    0:       stall_left = 0;
                    1:       stall_left = $urandom_range(10, 30);
                    default: stall_left = $urandom_range(1, 4);
                endcase
                m_ready <= (run_left > 0);
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
